@@ hw/rtl/priority_ready_queue_defines.svh @@
// ----------------------------------------------------------------------------
// priority_ready_queue_defines
// Assertion macros shared by the checker of the ready queue.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

// Condition that holds at every edge out of reset.
`define PRQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that holds in the cycle after the trigger.
`define PRQ_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ hw/rtl/prq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg
// Types and constants of the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

	localparam int FUNC_W     = 2;
	localparam int ID_W       = 6;
	localparam int LVL_W      = 8;
	localparam int CNT_W      = 7;
	localparam int TASKS_DEF  = 64;
	localparam int LEVELS_DEF = 256;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ENQ = 2'd0,
		FUNC_DEQ = 2'd1,
		FUNC_REQ = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_COMPACT,
		CMD_ROTATE
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_COMPACT,
		ST_ROTATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             v;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] lvl;
	} cell_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		cell_cmd_t        cmd;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] lvl;
		logic             front;
		logic [ID_W-1:0]  head_id;
	} cell_ctl_t;

	// What a cell shows to the controller and its neighbors.
	typedef struct packed {
		logic flag;
		logic seg;
		logic head;
		logic tail;
		logic hit;
	} cell_stat_t;

endpackage

@@ hw/rtl/prq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_cell
// One slot of the sorted task chain: valid, task id and level.
// ----------------------------------------------------------------------------
module prq_cell
	import prq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  cell_t      left,
	input  cell_stat_t left_stat,
	input  cell_t      right,
	input  cell_stat_t right_stat,
	output cell_t      data,
	output cell_stat_t stat
);

	cell_t data_q;
	cell_t data_nxt;

	always_comb begin
		stat.flag = data_q.v && (ctl.front ? (data_q.lvl > ctl.lvl) : (data_q.lvl >= ctl.lvl));
		stat.seg  = data_q.v && (data_q.lvl == ctl.lvl);
		stat.head = stat.seg && !left_stat.seg;
		stat.tail = stat.seg && !right_stat.seg;
		stat.hit  = data_q.v && (data_q.id == ctl.id);
	end

	always_comb begin
		data_nxt = data_q;
		unique case (ctl.cmd)
			CMD_INSERT: begin
				// chain is sorted, so the flags form a prefix
				if (!stat.flag) begin
					if (left_stat.flag) begin
						data_nxt = '{v: 1'b1, id: ctl.id, lvl: ctl.lvl};
					end else begin
						data_nxt = left;
					end
				end
			end
			CMD_REMOVE: begin
				if (stat.hit) begin
					data_nxt.v = 1'b0;
				end
			end
			CMD_COMPACT: begin
				// the single hole moves one slot toward the end
				if (!data_q.v && right.v) begin
					data_nxt = right;
				end else if (data_q.v && !left.v) begin
					data_nxt.v = 1'b0;
				end
			end
			CMD_ROTATE: begin
				if (stat.tail) begin
					data_nxt = '{v: 1'b1, id: ctl.head_id, lvl: ctl.lvl};
				end else if (stat.seg) begin
					data_nxt = right;
				end
			end
			default: begin
				data_nxt = data_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			data_q <= data_nxt;
		end
	end

	assign data = data_q;

endmodule

@@ hw/rtl/priority_ready_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue
// Scheduler ready queue kept as a chain of cells sorted by level, FIFO inside unless an enqueue sets at_front.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one item: func, task_id,
// task_prio, at_front. The block works on one item at a time and holds
// in_stall high from the cycle after acceptance until its result is loaded.
// Output channel (out_valid / out_stall) gives one result per item from an
// output register; a new item is taken while that result still waits.
// Steps from acceptance to out_valid: decode, then per item
//   enqueue and ignored items: nothing more,
//   dequeue: compaction while the freed hole travels (<= TASKS-1 slots),
//   requeue of a queued task: one head-to-tail move of its level at a
//   time (<= TASKS-1 moves) until the task is the tail,
// then done and the output load. The chain shifts one slot per cycle
// in compaction and rotation. Once an item is done, cell 0 holds the next task to run.
// Reset empties the chain and clears the count; no clearing pass is needed.
// While out_stall and out_valid are high a finished result waits in its state and the
// output register holds.
// ----------------------------------------------------------------------------
module priority_ready_queue
	import prq_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF,
	parameter int TASKS  = TASKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [ID_W-1:0]   task_id,
	input  logic [LVL_W-1:0]  task_prio,
	input  logic              at_front,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              next_valid,
	output logic [ID_W-1:0]   next_task,
	output logic [LVL_W-1:0]  highest_prio,
	output logic [CNT_W-1:0]  queued_total,
	output logic              op_ignored
);

	state_t            state_q;
	state_t            state_nxt;
	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   id_q;
	logic [LVL_W-1:0]  lvl_q;
	logic              front_q;
	logic              ign_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic              next_valid_q;
	logic [ID_W-1:0]   next_task_q;
	logic [LVL_W-1:0]  highest_q;
	logic [CNT_W-1:0]  total_q;
	logic              ignored_q;

	cell_ctl_t  ctl;
	cell_t      cdata [TASKS];
	cell_stat_t cstat [TASKS];

	logic             any_hit;
	logic [LVL_W-1:0] hit_lvl;
	logic [ID_W-1:0]  head_id;
	logic [ID_W-1:0]  tail_id;
	logic             pending;
	logic             op_ign;
	logic             op_ins;
	logic             op_rem;
	logic             out_load;
	logic [LVL_W-1:0] sat_lvl;

	// chain
	for (genvar i = 0; i < TASKS; i++) begin : g_cell
		cell_t      l_d;
		cell_stat_t l_s;
		cell_t      r_d;
		cell_stat_t r_s;
		if (i == 0) begin : g_first
			assign l_d = '{v: 1'b1, id: '0, lvl: '0};
			assign l_s = '{flag: 1'b1, seg: 1'b0, head: 1'b0, tail: 1'b0, hit: 1'b0};
		end else begin : g_mid_l
			assign l_d = cdata[i-1];
			assign l_s = cstat[i-1];
		end
		if (i == TASKS - 1) begin : g_last
			assign r_d = '{v: 1'b0, id: '0, lvl: '0};
			assign r_s = '{flag: 1'b0, seg: 1'b0, head: 1'b0, tail: 1'b0, hit: 1'b0};
		end else begin : g_mid_r
			assign r_d = cdata[i+1];
			assign r_s = cstat[i+1];
		end
		prq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left       (l_d),
			.left_stat  (l_s),
			.right      (r_d),
			.right_stat (r_s),
			.data       (cdata[i]),
			.stat       (cstat[i])
		);
	end

	// one-hot gathers over the cells
	always_comb begin
		any_hit = 1'b0;
		hit_lvl = '0;
		head_id = '0;
		tail_id = '0;
		pending = 1'b0;
		for (int i = 0; i < TASKS; i++) begin
			any_hit = any_hit | cstat[i].hit;
			hit_lvl = hit_lvl | (cstat[i].hit ? cdata[i].lvl : '0);
			head_id = head_id | (cstat[i].head ? cdata[i].id : '0);
			tail_id = tail_id | (cstat[i].tail ? cdata[i].id : '0);
		end
		for (int i = 0; i < TASKS - 1; i++) begin
			pending = pending | (!cdata[i].v && cdata[i+1].v);
		end
	end

	always_comb begin
		if (32'(task_prio) >= LEVELS) begin
			sat_lvl = LVL_W'(LEVELS - 1);
		end else begin
			sat_lvl = task_prio;
		end
	end

	// decode of the held item against the chain
	always_comb begin
		op_ign = 1'b0;
		op_ins = 1'b0;
		op_rem = 1'b0;
		if (32'(id_q) >= TASKS) begin
			op_ign = 1'b1;
		end else begin
			unique case (func_q)
				FUNC_ENQ: begin
					op_ign = any_hit;
					op_ins = !any_hit;
				end
				FUNC_DEQ: begin
					op_ign = !any_hit;
					op_rem = any_hit;
				end
				FUNC_REQ: begin
					op_ins = !any_hit;
				end
				default: begin
					op_ign = 1'b1;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (op_ign || op_ins) begin
					state_nxt = ST_DONE;
				end else if (op_rem) begin
					state_nxt = ST_COMPACT;
				end else begin
					state_nxt = ST_ROTATE;
				end
			end
			ST_COMPACT: begin
				if (!pending) begin
					state_nxt = ST_DONE;
				end
			end
			ST_ROTATE: begin
				if (tail_id == id_q) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctl.cmd     = CMD_HOLD;
		ctl.id      = id_q;
		ctl.lvl     = lvl_q;
		ctl.front   = front_q && (func_q == FUNC_ENQ);
		ctl.head_id = head_id;
		in_stall    = 1'b1;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_DECODE: begin
				if (op_ins) begin
					ctl.cmd = CMD_INSERT;
				end else if (op_rem) begin
					ctl.cmd = CMD_REMOVE;
				end
			end
			ST_COMPACT: begin
				ctl.cmd = CMD_COMPACT;
			end
			ST_ROTATE: begin
				if (tail_id != id_q) begin
					ctl.cmd = CMD_ROTATE;
				end
			end
			ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				ctl.cmd = CMD_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DECODE) begin
				if (op_ins) begin
					count_q <= count_q + CNT_W'(1);
				end else if (op_rem) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q  <= func;
			id_q    <= task_id;
			lvl_q   <= sat_lvl;
			front_q <= at_front;
		end else if (state_q == ST_DECODE) begin
			ign_q <= op_ign;
			// a rotation works on the level the task sits in
			if (!op_ign && !op_ins && !op_rem) begin
				lvl_q <= hit_lvl;
			end
		end
		if (out_load) begin
			next_valid_q <= cdata[0].v;
			next_task_q  <= cdata[0].v ? cdata[0].id : '0;
			highest_q    <= cdata[0].v ? cdata[0].lvl : '0;
			total_q      <= count_q;
			ignored_q    <= ign_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_valid   = next_valid_q;
	assign next_task    = next_task_q;
	assign highest_prio = highest_q;
	assign queued_total = total_q;
	assign op_ignored   = ignored_q;

endmodule

@@ hw/rtl/prq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_checker
// Port-level checks of the priority ready queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_defines.svh"

module prq_checker
	import prq_pkg::*;
#(
	parameter int TASKS = TASKS_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic             next_valid,
	input logic [ID_W-1:0]  next_task,
	input logic [LVL_W-1:0] highest_prio,
	input logic [CNT_W-1:0] queued_total
);

	`PRQ_ASSERT_ALWAYS(a_empty_result, clk, arst_n,
		!(out_valid && !next_valid) || (next_task == '0 && highest_prio == '0 && queued_total == '0),
		"empty queue result carries nonzero fields")

	`PRQ_ASSERT_ALWAYS(a_count_bound, clk, arst_n,
		!out_valid || (32'(queued_total) <= TASKS), "queued count above task limit")

	`PRQ_ASSERT_ALWAYS(a_nonempty_count, clk, arst_n,
		!(out_valid && next_valid) || (queued_total != '0), "next task shown with zero count")

	`PRQ_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && !in_stall, in_stall,
		"second item taken while one is at work")

	`PRQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(next_task) && $stable(queued_total), "stalled result changed")

endmodule

bind priority_ready_queue prq_checker #(.TASKS(TASKS)) u_prq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.next_valid   (next_valid),
	.next_task    (next_task),
	.highest_prio (highest_prio),
	.queued_total (queued_total)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives enqueue, dequeue and requeue items into the ready queue, predicts
// the next task, highest level, count and ignored flag with a linked-list
// copy of the queue, and compares every result under random idling and output stalls.
// ----------------------------------------------------------------------------
module testbench;
	import prq_pkg::*;

	localparam int NTASK = 64;
	localparam int NLVL  = 256;
	localparam int WATCHDOG = 4000;

	typedef struct packed {
		logic [FUNC_W-1:0] f;
		logic [ID_W-1:0]   id;
		logic [LVL_W-1:0]  prio;
		logic              front;
	} op_t;

	typedef struct packed {
		logic             nv;
		logic [ID_W-1:0]  nt;
		logic [LVL_W-1:0] hp;
		logic [CNT_W-1:0] cnt;
		logic             ign;
	} sched_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0;
	logic in_stall, out_valid;
	logic [FUNC_W-1:0] func = '0;
	logic [ID_W-1:0] task_id = '0;
	logic [LVL_W-1:0] task_prio = '0;
	logic at_front = 0;
	logic next_valid, op_ignored;
	logic [ID_W-1:0] next_task;
	logic [LVL_W-1:0] highest_prio;
	logic [CNT_W-1:0] queued_total;

	priority_ready_queue dut (.*);

	// shadow copy of the queue
	bit              q_on [NTASK];
	bit [LVL_W-1:0]  q_lvl [NTASK];
	bit [ID_W-1:0]   q_nxt [NTASK];
	bit [ID_W-1:0]   q_prv [NTASK];
	bit [ID_W-1:0]   l_head [NLVL];
	bit [ID_W-1:0]   l_tail [NLVL];
	bit              l_full [NLVL];
	int              top_lvl, n_queued;

	op_t    pending_ops[$];
	sched_t expected_sched[$];
	int     send_idle_pct, stall_pct, errors, quiet_cycles;
	bit     hold_send;

	initial forever #2 clk = ~clk;

	function automatic void link_task(int t, int lvl, bit front);
		if (!l_full[lvl]) begin
			l_head[lvl] = t; l_tail[lvl] = t; l_full[lvl] = 1;
		end else if (front) begin
			q_nxt[t] = l_head[lvl]; q_prv[l_head[lvl]] = t; l_head[lvl] = t;
		end else begin
			q_prv[t] = l_tail[lvl]; q_nxt[l_tail[lvl]] = t; l_tail[lvl] = t;
		end
		q_lvl[t] = lvl; q_on[t] = 1;
		if (lvl > top_lvl) top_lvl = lvl;
		n_queued++;
	endfunction

	function automatic void unlink_task(int t);
		int lvl, h, tl;
		lvl = q_lvl[t]; h = l_head[lvl]; tl = l_tail[lvl];
		if (h == t && tl == t) l_full[lvl] = 0;
		else begin
			if (h == t) l_head[lvl] = q_nxt[t];
			else q_nxt[q_prv[t]] = q_nxt[t];
			if (tl == t) l_tail[lvl] = q_prv[t];
			else q_prv[q_nxt[t]] = q_prv[t];
		end
		q_on[t] = 0;
		while (top_lvl > 0 && !l_full[top_lvl]) top_lvl--;
		n_queued--;
	endfunction

	function automatic void rotate_to_tail(int t);
		int lvl, h, tl;
		lvl = q_lvl[t]; h = l_head[lvl]; tl = l_tail[lvl];
		if (tl != t) begin
			q_nxt[tl] = h; q_prv[h] = tl;
			l_head[lvl] = q_nxt[t]; l_tail[lvl] = t;
		end
	endfunction

	function automatic sched_t schedule_op(op_t op);
		sched_t r;
		bit ign;
		ign = 0;
		case (op.f)
			FUNC_ENQ: begin
				if (q_on[op.id]) ign = 1;
				else link_task(op.id, op.prio, op.front);
			end
			FUNC_DEQ: begin
				if (!q_on[op.id]) ign = 1;
				else unlink_task(op.id);
			end
			FUNC_REQ: begin
				if (!q_on[op.id]) link_task(op.id, op.prio, 0);
				else rotate_to_tail(op.id);
			end
			default: ign = 1;
		endcase
		r.nv = l_full[top_lvl];
		r.nt = r.nv ? l_head[top_lvl] : '0;
		r.hp = top_lvl;
		r.cnt = n_queued;
		r.ign = ign;
		return r;
	endfunction

	function automatic op_t make_op(int f, int id, int prio, int front);
		op_t o;
		o.f = f; o.id = id; o.prio = prio; o.front = front;
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_sched.push_back(schedule_op({func, task_id, task_prio, at_front}));
		end
		if (!in_valid || !in_stall) begin
			if (pending_ops.size() > 0 && !hold_send &&
			    $urandom_range(99) >= send_idle_pct) begin
				op_t o;
				o = pending_ops.pop_front();
				in_valid  <= 1;
				func      <= o.f;
				task_id   <= o.id;
				task_prio <= o.prio;
				at_front  <= o.front;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sched_t e;
			sched_t a;
			a = {next_valid, next_task, highest_prio, queued_total, op_ignored};
			if (expected_sched.size() == 0) begin
				$display("%0t: unexpected result %h", $time, a);
				errors++;
			end else begin
				e = expected_sched.pop_front();
				if (a !== e) begin
					$display("%0t: mismatch exp nv=%0d nt=%0d hp=%0d cnt=%0d ign=%0d",
					         $time, e.nv, e.nt, e.hp, e.cnt, e.ign);
					$display("%0t:          act nv=%0d nt=%0d hp=%0d cnt=%0d ign=%0d",
					         $time, a.nv, a.nt, a.hp, a.cnt, a.ign);
					errors++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_ops.size() > 0 || in_valid || expected_sched.size() > 0)
			@(posedge clk);
	endtask

	// mostly well-formed traffic over a small set of levels so lists grow long
	task automatic add_random(int n);
		int f, k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			f = k < 40 ? FUNC_ENQ : k < 70 ? FUNC_DEQ : k < 97 ? FUNC_REQ : 3;
			pending_ops.push_back(make_op(f, $urandom_range(NTASK - 1),
				$urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(4) * 60,
				$urandom_range(1)));
		end
	endtask

	initial begin
		errors = 0; quiet_cycles = 0; hold_send = 0;
		send_idle_pct = 0; stall_pct = 0;
		top_lvl = 0; n_queued = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// empty dequeue, extremes, front/back, duplicates, rotations, func 3
		pending_ops.push_back(make_op(FUNC_DEQ, 5, 0, 0));
		pending_ops.push_back(make_op(FUNC_ENQ, 0, 0, 0));
		pending_ops.push_back(make_op(FUNC_ENQ, 63, 255, 1));
		pending_ops.push_back(make_op(FUNC_ENQ, 63, 10, 0));
		pending_ops.push_back(make_op(FUNC_ENQ, 1, 255, 0));
		pending_ops.push_back(make_op(FUNC_ENQ, 2, 255, 1));
		pending_ops.push_back(make_op(FUNC_ENQ, 3, 255, 0));
		pending_ops.push_back(make_op(FUNC_REQ, 1, 0, 0));
		pending_ops.push_back(make_op(FUNC_REQ, 1, 0, 1));
		pending_ops.push_back(make_op(FUNC_REQ, 4, 255, 1));
		pending_ops.push_back(make_op(3, 42, 170, 1));
		pending_ops.push_back(make_op(FUNC_DEQ, 3, 0, 0));
		pending_ops.push_back(make_op(FUNC_DEQ, 2, 0, 0));
		pending_ops.push_back(make_op(FUNC_DEQ, 63, 0, 0));
		pending_ops.push_back(make_op(FUNC_DEQ, 4, 0, 0));
		pending_ops.push_back(make_op(FUNC_DEQ, 1, 0, 0));
		pending_ops.push_back(make_op(FUNC_DEQ, 1, 0, 0));
		pending_ops.push_back(make_op(FUNC_DEQ, 0, 0, 0));
		for (int i = 0; i < 64; i++)
			pending_ops.push_back(make_op(FUNC_ENQ, i, 85, i % 2));
		for (int i = 0; i < 4; i++)
			pending_ops.push_back(make_op(FUNC_REQ, 21 * i, 0, 0));
		wait_drained();

		// full queue, hold the sender with items waiting, then release it and wait for all results
		hold_send = 1;
		add_random(220);
		repeat (20) @(posedge clk);
		hold_send = 0;
		wait_drained();

		send_idle_pct = 58; add_random(220); wait_drained();
		send_idle_pct = 0; stall_pct = 58; add_random(220); wait_drained();
		send_idle_pct = 14; stall_pct = 14; add_random(220); wait_drained();
		stall_pct = 0;
		repeat (200) @(posedge clk);

		if (errors == 0) $display("testbench: done, clean");
		else $display("testbench: done, errors");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/prq_pkg.sv
hw/rtl/prq_cell.sv
hw/rtl/priority_ready_queue.sv
hw/rtl/prq_checker.sv
sim/testbench.sv
